[hw/rtl/running_rmse_three_estimators_macros.svh]
// Assertion macros for the running RMSE block.
`ifndef RUNNING_RMSE_THREE_ESTIMATORS_MACROS_SVH
`define RUNNING_RMSE_THREE_ESTIMATORS_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define RRMSE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define RRMSE_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hw/rtl/rrmse_pkg.sv]
// Shared types and constants for the running RMSE block.
`timescale 1ns / 1ps
`default_nettype none
package rrmse_pkg;
    localparam int NUM_LANES = 9;
    localparam int SUM_W     = 58;
    localparam int RMS_W     = 16;
    localparam int OUT_CNT_W = 24;
    localparam int DIFF_W    = 17;
    localparam int SQ_W      = 34;
    localparam int SQRT_W    = 64;
    localparam int CNT_IDX_W = 7;

    typedef struct packed {
        logic start;
        logic acc_en;
    } lane_ctl_t;
endpackage
`default_nettype wire

[hw/rtl/rrmse_lane.sv]
// One error lane: squared-error accumulator, restoring divider, bit-pair square root.
`timescale 1ns / 1ps
`default_nettype none
module rrmse_lane #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 24
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire rrmse_pkg::lane_ctl_t       ctl,
    input  wire signed [SAMPLE_BITS-1:0]    ref_val,
    input  wire signed [SAMPLE_BITS-1:0]    est_val,
    input  wire        [COUNT_BITS-1:0]     count,
    output logic       [rrmse_pkg::RMS_W-1:0] rms,
    output logic                            done
);
    localparam int SW  = rrmse_pkg::SUM_W;
    localparam int QW  = SW;
    localparam int RW  = SW + 1;
    localparam int DIV_STEPS = SW;
    localparam int SQ_STEPS  = 29;
    localparam int STEP_W    = 7;
    localparam logic [1:0] ST_IDLE = 2'd0, ST_DIV = 2'd1, ST_SQRT = 2'd2;

    logic [SW-1:0] sum_reg, sum_next;
    logic [1:0] state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [SW-1:0] root_reg, root_next;
    logic [rrmse_pkg::RMS_W-1:0] rms_reg, rms_next;
    logic done_reg, done_next;

    logic signed [SAMPLE_BITS:0] diff;
    logic [2*SAMPLE_BITS+1:0] sq;
    logic [RW-1:0] rem_sh, trial;
    logic [SW+1:0] sq_rem, sq_try;

    assign diff = {ref_val[SAMPLE_BITS-1], ref_val} - {est_val[SAMPLE_BITS-1], est_val};
    assign sq   = (2*SAMPLE_BITS+2)'(diff * diff);

    always_comb begin
        sum_next = sum_reg; state_next = state_reg; step_next = step_reg;
        quo_next = quo_reg; rem_next = rem_reg; root_next = root_reg;
        rms_next = rms_reg; done_next = 1'b0;
        rem_sh = '0; trial = '0; sq_rem = '0; sq_try = '0;
        if (ctl.acc_en) begin
            sum_next = sum_reg + SW'(sq);
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (ctl.start) begin
                    if (count == '0) begin
                        rms_next = '0; done_next = 1'b1;
                    end else begin
                        quo_next = sum_next; rem_next = '0;
                        step_next = '0; state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                rem_sh = {rem_reg[RW-2:0], quo_reg[QW-1]};
                trial  = rem_sh - RW'(count);
                quo_next = {quo_reg[QW-2:0], ~trial[RW-1]};
                rem_next = trial[RW-1] ? rem_sh : trial;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    step_next = '0; root_next = '0; rem_next = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                // quotient shifts out two bits per step; rem holds partial remainder
                sq_rem = {rem_reg[SW-1:0], quo_reg[QW-1:QW-2]};
                sq_try = sq_rem - {root_reg[SW-1:0], 2'b01};
                if (!sq_try[SW+1]) begin
                    rem_next  = RW'(sq_try);
                    root_next = {root_reg[SW-2:0], 1'b1};
                end else begin
                    rem_next  = RW'(sq_rem);
                    root_next = {root_reg[SW-2:0], 1'b0};
                end
                quo_next  = {quo_reg[QW-3:0], 2'b00};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SQ_STEPS - 1)) begin
                    rms_next = root_next[rrmse_pkg::RMS_W-1:0];
                    done_next = 1'b1; state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0; state_reg <= ST_IDLE; done_reg <= 1'b0;
        end else begin
            sum_reg <= sum_next; state_reg <= state_next; done_reg <= done_next;
        end
        step_reg <= step_next; quo_reg <= quo_next; rem_reg <= rem_next;
        root_reg <= root_next; rms_reg <= rms_next;
    end

    assign rms  = rms_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

[hw/rtl/running_rmse_three_estimators.sv]
// Running RMSE of three estimators against a reference: top level.
// Each accepted beat updates nine squared-error sums and the sample count (both hold
// once the count is saturated), then nine lanes each run a 58-step restoring divide
// by the count and a 29-step bit-pair square root before the result is valid (a zero
// count skips both, but it cannot follow an accepted beat).
// The lanes run together; their results are merged into one output register.
// A new beat is taken only once the output register has been read out (m_tready).
`timescale 1ns / 1ps
`default_nettype none
`include "running_rmse_three_estimators_macros.svh"
module running_rmse_three_estimators #(
    parameter int COUNT_BITS  = 24,
    parameter int SAMPLE_BITS = 16
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // ref_x, ref_y, ref_z, est_a_x..z, est_b_x..z, est_c_x..z (16 bits each)
    input  wire  [191:0] s_tdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    // rmse_a_x..rmse_c_z (16 each), samples_seen (24), count_full (1), zero pad
    output logic [175:0] m_tdata
);
    localparam int NL = rrmse_pkg::NUM_LANES;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic busy_reg, busy_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic out_v_reg, out_v_next;
    logic [175:0] out_reg, out_next;
    logic accept;
    rrmse_pkg::lane_ctl_t ctl;
    logic [rrmse_pkg::RMS_W-1:0] rms [NL];
    logic [NL-1:0] done;

    assign s_tready = !busy_reg && !out_v_reg;
    assign accept   = s_tvalid && s_tready;
    assign ctl.start  = accept;
    assign ctl.acc_en = accept && (cnt_reg != CNT_MAX);
    assign cnt_next   = ctl.acc_en ? cnt_reg + 1'b1 : cnt_reg;

    for (genvar e = 0; e < 3; e++) begin : g_est
        for (genvar k = 0; k < 3; k++) begin : g_axis
            rrmse_lane #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_lane (
                .aclk(aclk), .aresetn(aresetn), .ctl(ctl),
                .ref_val(s_tdata[k*16 +: SAMPLE_BITS]),
                .est_val(s_tdata[(3+e*3+k)*16 +: SAMPLE_BITS]),
                .count(cnt_next),
                .rms(rms[e*3+k]), .done(done[e*3+k])
            );
        end
    end

    always_comb begin
        busy_next = busy_reg; out_v_next = out_v_reg; out_next = out_reg;
        if (accept) busy_next = 1'b1;
        if (m_tvalid && m_tready) out_v_next = 1'b0;
        if (busy_reg && done[0]) begin
            busy_next = 1'b0; out_v_next = 1'b1;
            for (int i = 0; i < NL; i++) out_next[i*16 +: 16] = rms[i];
            out_next[144 +: 24] = 24'(cnt_reg);
            out_next[168] = (cnt_reg == CNT_MAX);
            out_next[175:169] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; cnt_reg <= '0; out_v_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next; cnt_reg <= cnt_next; out_v_reg <= out_v_next;
        end
        out_reg <= out_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

    `RRMSE_ASSERT_IMP(a_lanes_agree, aclk, aresetn, busy_reg, (done == '0) || (done == '1), "lanes out of step")
    `RRMSE_ASSERT_NXT(a_no_accept_busy, aclk, aresetn, accept, !s_tready, "beat taken while busy")
    `RRMSE_ASSERT_IMP(a_cnt_sat, aclk, aresetn, cnt_reg == CNT_MAX, !ctl.acc_en, "count grew past max")
endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// Stream testbench for the running RMSE block: RMS error predictor, result checking, random stalls.
`timescale 1ns / 1ps
`default_nettype none

class rmse_scoreboard;
    localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;
    logic [57:0]  err_sums[9];
    logic [23:0]  sets_taken;
    logic [175:0] pending_rms[$];
    int           fail_count;
    string        lane_names[9] = '{"rmse_a_x", "rmse_a_y", "rmse_a_z",
                                    "rmse_b_x", "rmse_b_y", "rmse_b_z",
                                    "rmse_c_x", "rmse_c_y", "rmse_c_z"};

    function new();
        foreach (err_sums[i]) err_sums[i] = '0;
        sets_taken = '0;
        fail_count = 0;
    endfunction

    function automatic logic [15:0] floor_sqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root[15:0];
    endfunction

    function void note_set(logic [191:0] set_bits);
        logic signed [16:0] diff;
        logic [33:0]        sq;
        logic [175:0]       rms;
        if (sets_taken < COUNT_MAX) begin
            for (int e = 0; e < 3; e++)
                for (int k = 0; k < 3; k++) begin
                    diff = $signed(set_bits[16*k +: 16])
                         - $signed(set_bits[16*(3 + 3*e + k) +: 16]);
                    sq = diff * diff;
                    err_sums[3*e + k] += 58'(sq);
                end
            sets_taken++;
        end
        rms = '0;
        for (int k = 0; k < 9; k++)
            if (sets_taken != 0)
                rms[16*k +: 16] = floor_sqrt(64'(err_sums[k] / sets_taken));
        rms[144 +: 24] = sets_taken;
        rms[168] = (sets_taken >= COUNT_MAX);
        pending_rms.push_back(rms);
    endfunction

    function void check_result(logic [175:0] got);
        logic [175:0] want;
        if (pending_rms.size() == 0) begin
            $error("result with no set pending: %h", got);
            fail_count++;
            return;
        end
        want = pending_rms.pop_front();
        for (int k = 0; k < 9; k++)
            if (got[16*k +: 16] !== want[16*k +: 16]) begin
                $error("%s: expected %0d, got %0d", lane_names[k],
                       want[16*k +: 16], got[16*k +: 16]);
                fail_count++;
            end
        if (got[144 +: 24] !== want[144 +: 24]) begin
            $error("samples_seen: expected %0d, got %0d", want[144 +: 24], got[144 +: 24]);
            fail_count++;
        end
        if (got[168] !== want[168]) begin
            $error("count_full: expected %0d, got %0d", want[168], got[168]);
            fail_count++;
        end
        if (got[175:169] !== '0) begin
            $error("pad bits: expected 0, got %h", got[175:169]);
            fail_count++;
        end
    endfunction
endclass

module tb_top;
    localparam int WATCHDOG_LIMIT = 4000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [175:0] m_tdata;

    rmse_scoreboard rms_board;
    bit  quiet_mode;
    bit  hold_off_req;
    int  idle_cycles;

    running_rmse_three_estimators uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) rms_board.note_set(s_tdata);
            if (m_tvalid && m_tready) rms_board.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stalls, a quiet stretch, and one long hold-off on request
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                hold_off_req = 1'b0;
                repeat (600) @(negedge aclk);
            end
            m_tready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 8);
        end
    end

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'(($urandom_range(255)) - 128);
            default: return 16'($urandom);
        endcase
    endfunction

    // tvalid stays up after a beat; the next set or a drain decides what follows
    task automatic send_set(logic [191:0] set_bits);
        if (!quiet_mode && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= set_bits;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (rms_board.pending_rms.size() != 0);
    endtask

    task automatic random_set();
        logic [191:0] set_bits;
        logic [15:0]  base;
        base = pick_sample();
        for (int f = 0; f < 12; f++)
            set_bits[16*f +: 16] = ($urandom_range(3) == 0) ? pick_sample()
                                 : base + 16'($urandom_range(64)) - 16'd32;
        send_set(set_bits);
    endtask

    initial begin
        logic [191:0] set_bits;
        rms_board   = new();
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        quiet_mode  = 1'b0;
        hold_off_req = 1'b0;
        idle_cycles = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: zero error, full-scale errors both ways, mixed signs
        send_set('0);
        send_set({12{16'h7FFF}});
        send_set({{9{16'h8000}}, {3{16'h7FFF}}});
        send_set({{9{16'h7FFF}}, {3{16'h8000}}});
        send_set({{9{16'h0000}}, {3{16'hFFFF}}});
        send_set({{9{16'hFFFF}}, {3{16'h0000}}});
        for (int f = 0; f < 12; f++) set_bits[16*f +: 16] = (f % 2) ? 16'h8000 : 16'h7FFF;
        send_set(set_bits);
        for (int f = 0; f < 12; f++) set_bits[16*f +: 16] = 16'(f * 16'h1111);
        send_set(set_bits);
        for (int f = 0; f < 12; f++) set_bits[16*f +: 16] = 16'h5555 ^ {16{f[0]}};
        send_set(set_bits);
        drain_results();

        for (int n = 0; n < 550; n++) begin
            quiet_mode = (n >= 200 && n < 300);
            if (n == 350) begin
                hold_off_req = 1'b1;
            end
            if (n == 450) drain_results();
            random_set();
        end
        quiet_mode = 1'b0;
        drain_results();
        repeat (200) @(negedge aclk);
        if (rms_board.fail_count == 0 && rms_board.pending_rms.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
